// ===== rtl/core/bgd_pkg.sv =====
// Package for the button gesture detector.
// Holds the config, flag-state and result structs and the register indexes.
// No dependencies.
`timescale 1ns / 1ps

package bgd_pkg;

  localparam int CfgWidth = 16;
  localparam int CfgAddrWidth = 2;

  localparam logic [CfgAddrWidth-1:0] REG_ACTIVE_LOW = 2'd0;
  localparam logic [CfgAddrWidth-1:0] REG_READ_GATE  = 2'd1;
  localparam logic [CfgAddrWidth-1:0] REG_TAP_WINDOW = 2'd2;
  localparam logic [CfgAddrWidth-1:0] REG_LONG_PRESS = 2'd3;

  localparam logic [CfgWidth-1:0] READ_GATE_RESET  = 16'd200;
  localparam logic [CfgWidth-1:0] TAP_WINDOW_RESET = 16'd300;
  localparam logic [CfgWidth-1:0] LONG_PRESS_RESET = 16'd500;

  localparam logic [1:0] TAP_MAX = 2'd3;

  typedef struct packed {
    logic                active_low;
    logic [CfgWidth-1:0] read_gate;
    logic [CfgWidth-1:0] tap_window;
    logic [CfgWidth-1:0] long_press;
  } cfg_t;

  typedef struct packed {
    logic       pressed;
    logic [1:0] tap_count;
    logic       click;
    logic       dbl;
    logic       long_hold;
  } flags_t;

  typedef struct packed {
    logic click_seen;
    logic double_seen;
    logic long_seen;
    logic is_pressed;
  } result_t;

endpackage

// ===== rtl/core/bgd_step.sv =====
// Next-state logic for one tick of the gesture detector.
// Read-and-clear of the event flags, then press/release edge rules.
// Depends on bgd_pkg.
`timescale 1ns / 1ps

module bgd_step import bgd_pkg::*; #(
  parameter int TIME_BITS = 16
) (
  input  cfg_t                 cfg,
  input  flags_t               flags,
  input  logic [TIME_BITS-1:0] ticks,
  input  logic                 pin_level,
  input  logic                 read_click,
  input  logic                 read_double,
  input  logic                 read_long,
  output flags_t               flags_next,
  output logic [TIME_BITS-1:0] ticks_next,
  output result_t              result
);

  localparam int CMP_W = (TIME_BITS > CfgWidth) ? TIME_BITS : CfgWidth;

  logic [CMP_W-1:0] t_ext;
  logic [CMP_W-1:0] gate_ext;
  logic [CMP_W-1:0] window_ext;
  logic [CMP_W-1:0] long_ext;
  logic             level;
  logic             edge_seen;
  logic             in_window;
  logic             click_rd;
  logic             double_rd;
  logic [1:0]       tap_inc;
  flags_t           f;

  assign t_ext      = CMP_W'(ticks);
  assign gate_ext   = CMP_W'(cfg.read_gate);
  assign window_ext = CMP_W'(cfg.tap_window);
  assign long_ext   = CMP_W'(cfg.long_press);

  assign level     = cfg.active_low ? ~pin_level : pin_level;
  assign edge_seen = (level != flags.pressed);
  assign in_window = (t_ext < window_ext);
  assign click_rd  = read_click && (t_ext > gate_ext);
  assign double_rd = read_double && (t_ext < gate_ext);
  assign tap_inc   = (flags.tap_count == TAP_MAX) ? TAP_MAX : flags.tap_count + 2'd1;

  always_comb begin
    f = flags;
    // reads see the flags as they stood before this tick's edge
    if (click_rd) begin
      f.click = 1'b0;
    end
    if (double_rd) begin
      f.dbl = 1'b0;
    end
    if (read_long) begin
      f.long_hold = 1'b0;
    end

    if (edge_seen) begin
      if (!flags.pressed) begin
        f.tap_count = in_window ? tap_inc : 2'd0;
        f.pressed   = 1'b1;
      end else begin
        if (in_window) begin
          f.tap_count = tap_inc;
          if (tap_inc == 2'd1) begin
            f.click     = 1'b1;
            f.tap_count = 2'd0;
          end else if (tap_inc == 2'd2 && f.click) begin
            f.click     = 1'b0;
            f.dbl       = 1'b1;
            f.tap_count = 2'd0;
          end
        end else begin
          f.tap_count = 2'd0;
        end
        if (t_ext > long_ext) begin
          f.long_hold = 1'b1;
          f.tap_count = 2'd0;
        end
        f.pressed = 1'b0;
      end
    end
    flags_next = f;
  end

  always_comb begin
    if (edge_seen) begin
      ticks_next = '0;
    end else if (ticks != {TIME_BITS{1'b1}}) begin
      ticks_next = ticks + TIME_BITS'(1);
    end else begin
      ticks_next = ticks;
    end
  end

  assign result.click_seen  = click_rd & flags.click;
  assign result.double_seen = double_rd & flags.dbl;
  assign result.long_seen   = read_long & flags.long_hold;
  assign result.is_pressed  = f.pressed;

endmodule

// ===== rtl/core/button_gesture_detector_top.sv =====
// Button gesture detector: click, double click and long press from a tick stream.
// Result valid in the cycle after request accept; throughput 1 request/cycle while out_valid && out_stall is low.
// The tick state updates at accept; one result register decouples the output side.
// Synchronous active-high reset: config to defaults, state cleared, output empty.
// Depends on bgd_pkg and bgd_step.
`timescale 1ns / 1ps

module button_gesture_detector_top import bgd_pkg::*; #(
  parameter int TIME_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CfgAddrWidth-1:0] cfg_addr,
  input  logic [CfgWidth-1:0]     cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    pin_level,
  input  logic                    read_click,
  input  logic                    read_double,
  input  logic                    read_long,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    click_seen,
  output logic                    double_seen,
  output logic                    long_seen,
  output logic                    is_pressed
);

  cfg_t                 cfg;
  flags_t               flags;
  flags_t               flags_next;
  logic [TIME_BITS-1:0] ticks;
  logic [TIME_BITS-1:0] ticks_next;
  result_t              result;
  result_t              result_next;
  logic                 in_fire;

  // accept whenever the result slot is empty or being drained
  assign in_stall = out_valid && out_stall;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_low <= 1'b1;
      cfg.read_gate  <= READ_GATE_RESET;
      cfg.tap_window <= TAP_WINDOW_RESET;
      cfg.long_press <= LONG_PRESS_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ACTIVE_LOW: cfg.active_low <= cfg_wdata[0];
        REG_READ_GATE:  cfg.read_gate  <= cfg_wdata;
        REG_TAP_WINDOW: cfg.tap_window <= cfg_wdata;
        REG_LONG_PRESS: cfg.long_press <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bgd_step #(
    .TIME_BITS(TIME_BITS)
  ) u_step (
    .cfg        (cfg),
    .flags      (flags),
    .ticks      (ticks),
    .pin_level  (pin_level),
    .read_click (read_click),
    .read_double(read_double),
    .read_long  (read_long),
    .flags_next (flags_next),
    .ticks_next (ticks_next),
    .result     (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      flags     <= '0;
      ticks     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        flags     <= flags_next;
        ticks     <= ticks_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result <= result_next;
    end
  end

  assign click_seen  = result.click_seen;
  assign double_seen = result.double_seen;
  assign long_seen   = result.long_seen;
  assign is_pressed  = result.is_pressed;

  a_pressed_matches : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_pressed == flags.pressed))
    else $error("shown pressed state differs from tracked state");

  a_fire_gives_result : assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted request produced no result");

  a_ticks_hold_idle : assert property (@(posedge clk) disable iff (rst)
    (!in_fire && !$past(rst)) |=> $stable(ticks) && $stable(flags))
    else $error("tick state changed without a request");

endmodule
